FILE: design/ppd_pkg.sv
package ppd_pkg;

  localparam int PIXEL_W   = 32;
  localparam int CNT_OUT_W = 24;
  localparam int SUM_OUT_W = 34;
  localparam int TOTAL_W   = 10;   // four 8-bit deltas
  localparam int SUM_EXTRA = 10;   // sum limit is count limit times 1020
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;

  localparam logic [7:0] CLOSE_DELTA = 8'd8;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LIMIT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LIMIT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIS_BY_ALPHA = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE  = 4'd3;

  localparam logic [7:0] ALPHA_LIMIT_RST = 8'd8;
  localparam logic [7:0] DARK_LIMIT_RST  = 8'd4;

  typedef struct packed {
    logic [7:0] alpha_limit;
    logic [7:0] dark_limit;
    logic       visibility_by_alpha;
    logic       mask_enable;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] left_pixel;
    logic [PIXEL_W-1:0] right_pixel;
    logic [PIXEL_W-1:0] mask_pixel;
    logic               frame_end;
  } sample_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               close;
    logic               left_vis;
    logic               right_vis;
    logic               fg;
    logic               last;
  } metrics_t;

endpackage

FILE: design/ppd_pixel_eval.sv
module ppd_pixel_eval (
  input  logic               clk,
  input  logic               rst,
  input  ppd_pkg::cfg_t      cfg,
  input  logic               load,
  input  logic               src_valid,
  input  ppd_pkg::sample_t   src,
  output logic               metr_valid,
  output ppd_pkg::metrics_t  metr
);

  logic [3:0][7:0]             delta;
  logic [ppd_pkg::TOTAL_W-1:0] total;
  logic                        close;
  logic                        left_vis;
  logic                        right_vis;
  logic                        mask_fg;

  function automatic logic visible(input logic [ppd_pkg::PIXEL_W-1:0] px,
                                   input ppd_pkg::cfg_t c);
    logic res;
    if (c.visibility_by_alpha) begin
      res = px[31:24] > c.alpha_limit;
    end else begin
      res = (px[7:0] > c.dark_limit) || (px[15:8] > c.dark_limit) ||
            (px[23:16] > c.dark_limit);
    end
    return res;
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (src.left_pixel[8*k +: 8] > src.right_pixel[8*k +: 8]) begin
        delta[k] = src.left_pixel[8*k +: 8] - src.right_pixel[8*k +: 8];
      end else begin
        delta[k] = src.right_pixel[8*k +: 8] - src.left_pixel[8*k +: 8];
      end
    end
  end

  assign total = ppd_pkg::TOTAL_W'(delta[0]) + ppd_pkg::TOTAL_W'(delta[1]) +
                 ppd_pkg::TOTAL_W'(delta[2]) + ppd_pkg::TOTAL_W'(delta[3]);

  assign close = (delta[0] <= ppd_pkg::CLOSE_DELTA) && (delta[1] <= ppd_pkg::CLOSE_DELTA) &&
                 (delta[2] <= ppd_pkg::CLOSE_DELTA) && (delta[3] <= ppd_pkg::CLOSE_DELTA);

  assign left_vis  = visible(src.left_pixel, cfg);
  assign right_vis = visible(src.right_pixel, cfg);

  // mask test compares every byte against the alpha limit
  assign mask_fg = (src.mask_pixel[7:0]   > cfg.alpha_limit) ||
                   (src.mask_pixel[15:8]  > cfg.alpha_limit) ||
                   (src.mask_pixel[23:16] > cfg.alpha_limit) ||
                   (src.mask_pixel[31:24] > cfg.alpha_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      metr_valid <= 1'b0;
    end else if (load) begin
      metr_valid <= src_valid;
    end
    if (load) begin
      metr.total     <= total;
      metr.close     <= close;
      metr.left_vis  <= left_vis;
      metr.right_vis <= right_vis;
      metr.fg        <= cfg.mask_enable ? mask_fg : (left_vis || right_vis);
      metr.last      <= src.frame_end;
    end
  end

endmodule

FILE: design/ppd_sat_acc.sv
module ppd_sat_acc #(
  parameter int WIDTH    = 24,
  parameter int AMT_BITS = 1,
  parameter logic [WIDTH-1:0] LIMIT = '1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                hit,
  input  logic                clear,
  input  logic [AMT_BITS-1:0] amount,
  output logic [WIDTH-1:0]    value,
  output logic [WIDTH-1:0]    value_next,
  output logic                sat_hit
);

  logic [WIDTH-1:0] amt;
  logic             reach;

  assign amt   = WIDTH'(amount);
  assign reach = amt >= (LIMIT - value);

  assign sat_hit    = hit && reach;
  assign value_next = !hit ? value : (reach ? LIMIT : value + amt);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (step) begin
      value <= clear ? '0 : value_next;
    end
  end

endmodule

FILE: design/ppd_accum.sv
module ppd_accum #(
  parameter int COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            metr_valid,
  input  ppd_pkg::metrics_t               metr,
  output logic                            ready,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   sample_total,
  output logic [ppd_pkg::SUM_OUT_W-1:0]   diff_sum,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   close_total,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   fg_total,
  output logic [ppd_pkg::SUM_OUT_W-1:0]   fg_diff_sum,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   fg_close_total,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   union_total,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   overlap_total,
  output logic                            saturated
);

  localparam int SUM_BITS = COUNT_BITS + ppd_pkg::SUM_EXTRA;
  localparam logic [COUNT_BITS-1:0] CNT_LIMIT = '1;
  localparam logic [SUM_BITS-1:0] SUM_LIMIT =
    SUM_BITS'(SUM_BITS'(CNT_LIMIT) * SUM_BITS'(1020));

  localparam int N_ACC = 8;

  logic step;
  logic clear;
  logic [N_ACC-1:0] hits;
  logic sat;
  logic sat_next;

  logic [COUNT_BITS-1:0] cnt_sample, cnt_sample_n;
  logic [COUNT_BITS-1:0] cnt_close, cnt_close_n;
  logic [COUNT_BITS-1:0] cnt_fg, cnt_fg_n;
  logic [COUNT_BITS-1:0] cnt_fg_close, cnt_fg_close_n;
  logic [COUNT_BITS-1:0] cnt_union, cnt_union_n;
  logic [COUNT_BITS-1:0] cnt_overlap, cnt_overlap_n;
  logic [SUM_BITS-1:0]   sum_diff, sum_diff_n;
  logic [SUM_BITS-1:0]   sum_fg_diff, sum_fg_diff_n;

  // a frame-end beat waits for the result slot; others never block
  assign ready = !metr.last || !out_valid || !out_stall;
  assign step  = metr_valid && ready;
  assign clear = metr.last;

  ppd_sat_acc #(.WIDTH(COUNT_BITS), .AMT_BITS(1), .LIMIT(CNT_LIMIT)) u_sample (
    .clk, .rst, .step, .clear, .hit(1'b1), .amount(1'b1),
    .value(cnt_sample), .value_next(cnt_sample_n), .sat_hit(hits[0]));

  ppd_sat_acc #(.WIDTH(SUM_BITS), .AMT_BITS(ppd_pkg::TOTAL_W), .LIMIT(SUM_LIMIT)) u_diff (
    .clk, .rst, .step, .clear, .hit(1'b1), .amount(metr.total),
    .value(sum_diff), .value_next(sum_diff_n), .sat_hit(hits[1]));

  ppd_sat_acc #(.WIDTH(COUNT_BITS), .AMT_BITS(1), .LIMIT(CNT_LIMIT)) u_close (
    .clk, .rst, .step, .clear, .hit(metr.close), .amount(1'b1),
    .value(cnt_close), .value_next(cnt_close_n), .sat_hit(hits[2]));

  ppd_sat_acc #(.WIDTH(COUNT_BITS), .AMT_BITS(1), .LIMIT(CNT_LIMIT)) u_union (
    .clk, .rst, .step, .clear, .hit(metr.left_vis || metr.right_vis), .amount(1'b1),
    .value(cnt_union), .value_next(cnt_union_n), .sat_hit(hits[3]));

  ppd_sat_acc #(.WIDTH(COUNT_BITS), .AMT_BITS(1), .LIMIT(CNT_LIMIT)) u_overlap (
    .clk, .rst, .step, .clear, .hit(metr.left_vis && metr.right_vis), .amount(1'b1),
    .value(cnt_overlap), .value_next(cnt_overlap_n), .sat_hit(hits[4]));

  ppd_sat_acc #(.WIDTH(COUNT_BITS), .AMT_BITS(1), .LIMIT(CNT_LIMIT)) u_fg (
    .clk, .rst, .step, .clear, .hit(metr.fg), .amount(1'b1),
    .value(cnt_fg), .value_next(cnt_fg_n), .sat_hit(hits[5]));

  ppd_sat_acc #(.WIDTH(SUM_BITS), .AMT_BITS(ppd_pkg::TOTAL_W), .LIMIT(SUM_LIMIT)) u_fg_diff (
    .clk, .rst, .step, .clear, .hit(metr.fg), .amount(metr.total),
    .value(sum_fg_diff), .value_next(sum_fg_diff_n), .sat_hit(hits[6]));

  ppd_sat_acc #(.WIDTH(COUNT_BITS), .AMT_BITS(1), .LIMIT(CNT_LIMIT)) u_fg_close (
    .clk, .rst, .step, .clear, .hit(metr.fg && metr.close), .amount(1'b1),
    .value(cnt_fg_close), .value_next(cnt_fg_close_n), .sat_hit(hits[7]));

  assign sat_next = sat || (|hits);

  always_ff @(posedge clk) begin
    if (rst) begin
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        sat <= sat_next;
      end
      if (step && metr.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (step && metr.last) begin
      sample_total   <= ppd_pkg::CNT_OUT_W'(cnt_sample_n);
      diff_sum       <= ppd_pkg::SUM_OUT_W'(sum_diff_n);
      close_total    <= ppd_pkg::CNT_OUT_W'(cnt_close_n);
      fg_total       <= ppd_pkg::CNT_OUT_W'(cnt_fg_n);
      fg_diff_sum    <= ppd_pkg::SUM_OUT_W'(sum_fg_diff_n);
      fg_close_total <= ppd_pkg::CNT_OUT_W'(cnt_fg_close_n);
      union_total    <= ppd_pkg::CNT_OUT_W'(cnt_union_n);
      overlap_total  <= ppd_pkg::CNT_OUT_W'(cnt_overlap_n);
      saturated      <= sat_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    step && metr.last |=> cnt_sample == '0 && sum_diff == '0 && cnt_fg == '0)
    else $error("totals not cleared after frame end");

  a_sample_count: assert property (@(posedge clk) disable iff (rst)
    step && !metr.last && cnt_sample != CNT_LIMIT |=> cnt_sample == $past(cnt_sample) + 1'b1)
    else $error("sample count did not advance");

  a_subset_counts: assert property (@(posedge clk) disable iff (rst)
    cnt_fg <= cnt_sample && cnt_overlap <= cnt_union && cnt_union <= cnt_sample &&
    cnt_fg_close <= cnt_close && cnt_fg_close <= cnt_fg && sum_fg_diff <= sum_diff)
    else $error("subset count exceeds its superset");

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    sat |=> sat)
    else $error("saturation flag dropped");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step && metr.last))
    else $error("result without frame-end beat");

endmodule

FILE: design/pixel_pair_diff_metrics.sv
// Per-frame difference and overlap totals over a stream of pixel pairs.
// Input channel: one beat per sampled pair (left_pixel, right_pixel,
// mask_pixel, all BGRA, plus frame_end), taken when in_valid && !in_stall.
// Output channel: one beat per frame, on the frame_end sample, carrying
// all totals including that sample, taken when out_valid && !out_stall.
// Config: cfg_we writes cfg_data into register cfg_index (0 alpha_limit,
// 1 dark_limit, 2 visibility_by_alpha, 3 mask_enable); other indexes are
// ignored. Write only while the pipeline is empty.
// Throughput: one beat per cycle when no stall holds the input, set by the
// accumulator update loop. The frame_end beat is registered in the input reg
// at accept, then in the metric reg, and the result reg is loaded from the
// accumulators as that beat leaves the metric reg.
// Stall: a waiting result blocks only the next frame_end beat; other beats
// keep flowing into the accumulators. in_stall rises when that beat backs
// up the two-stage pipe.
// Reset (rst, synchronous): clears the pipe, the totals, the sticky
// saturation flag and restores the register defaults.
module pixel_pair_diff_metrics #(
  parameter int COUNT_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppd_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ppd_pkg::PIXEL_W-1:0]     left_pixel,
  input  logic [ppd_pkg::PIXEL_W-1:0]     right_pixel,
  input  logic [ppd_pkg::PIXEL_W-1:0]     mask_pixel,
  input  logic                            frame_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   sample_total,
  output logic [ppd_pkg::SUM_OUT_W-1:0]   diff_sum,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   close_total,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   fg_total,
  output logic [ppd_pkg::SUM_OUT_W-1:0]   fg_diff_sum,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   fg_close_total,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   union_total,
  output logic [ppd_pkg::CNT_OUT_W-1:0]   overlap_total,
  output logic                            saturated
);

  ppd_pkg::cfg_t     cfg;
  ppd_pkg::sample_t  smp;
  ppd_pkg::metrics_t metr;
  logic              smp_valid;
  logic              smp_ready;
  logic              metr_valid;
  logic              metr_ready;
  logic              acc_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha_limit         <= ppd_pkg::ALPHA_LIMIT_RST;
      cfg.dark_limit          <= ppd_pkg::DARK_LIMIT_RST;
      cfg.visibility_by_alpha <= 1'b0;
      cfg.mask_enable         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppd_pkg::REG_ALPHA_LIMIT:  cfg.alpha_limit         <= cfg_data;
        ppd_pkg::REG_DARK_LIMIT:   cfg.dark_limit          <= cfg_data;
        ppd_pkg::REG_VIS_BY_ALPHA: cfg.visibility_by_alpha <= cfg_data[0];
        ppd_pkg::REG_MASK_ENABLE:  cfg.mask_enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-stage ready: a stage takes a beat when empty or draining
  assign metr_ready = !metr_valid || acc_ready;
  assign smp_ready  = !smp_valid || metr_ready;
  assign in_stall   = !smp_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (smp_ready) begin
      smp_valid <= in_valid;
    end
    if (smp_ready) begin
      smp.left_pixel  <= left_pixel;
      smp.right_pixel <= right_pixel;
      smp.mask_pixel  <= mask_pixel;
      smp.frame_end   <= frame_end;
    end
  end

  ppd_pixel_eval u_eval (
    .clk,
    .rst,
    .cfg,
    .load      (metr_ready),
    .src_valid (smp_valid),
    .src       (smp),
    .metr_valid,
    .metr
  );

  ppd_accum #(.COUNT_BITS(COUNT_BITS)) u_accum (
    .clk,
    .rst,
    .metr_valid,
    .metr,
    .ready     (acc_ready),
    .out_valid,
    .out_stall,
    .sample_total,
    .diff_sum,
    .close_total,
    .fg_total,
    .fg_diff_sum,
    .fg_close_total,
    .union_total,
    .overlap_total,
    .saturated
  );

endmodule

FILE: tb/sv/pixel_pair_diff_metrics_tb.sv
module pixel_pair_diff_metrics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Accumulators at the block's default width; the limits follow from it.
  localparam int ACC_BITS = 24;
  localparam longint unsigned COUNT_LIMIT = (64'd1 << ACC_BITS) - 1;
  localparam longint unsigned SUM_LIMIT = COUNT_LIMIT * 1020;

  // Spare register indexes; writes there must be dropped.
  localparam logic [ppd_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST =
    ppd_pkg::CFG_IDX_W'(ppd_pkg::REG_MASK_ENABLE + 1);
  localparam logic [ppd_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

  localparam int PIPE_FLUSH = 8;        // input reg + metric reg + result reg, with margin
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off in the pressure phase
  localparam int WATCHDOG_LIMIT = 3000; // idle cycles before the run is declared hung
  localparam int SAT_FRAME_LEN = 300;

  typedef struct packed {
    logic [ppd_pkg::CNT_OUT_W-1:0] sample_cnt;
    logic [ppd_pkg::SUM_OUT_W-1:0] diff_acc;
    logic [ppd_pkg::CNT_OUT_W-1:0] close_cnt;
    logic [ppd_pkg::CNT_OUT_W-1:0] fg_cnt;
    logic [ppd_pkg::SUM_OUT_W-1:0] fg_diff_acc;
    logic [ppd_pkg::CNT_OUT_W-1:0] fg_close_cnt;
    logic [ppd_pkg::CNT_OUT_W-1:0] union_cnt;
    logic [ppd_pkg::CNT_OUT_W-1:0] overlap_cnt;
    logic                          sat;
  } frame_totals_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_we = 1'b0;
  logic [ppd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ppd_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [ppd_pkg::PIXEL_W-1:0] left_pixel = '0;
  logic [ppd_pkg::PIXEL_W-1:0] right_pixel = '0;
  logic [ppd_pkg::PIXEL_W-1:0] mask_pixel = '0;
  logic                        frame_end = 1'b0;

  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ppd_pkg::CNT_OUT_W-1:0] sample_total;
  logic [ppd_pkg::SUM_OUT_W-1:0] diff_sum;
  logic [ppd_pkg::CNT_OUT_W-1:0] close_total;
  logic [ppd_pkg::CNT_OUT_W-1:0] fg_total;
  logic [ppd_pkg::SUM_OUT_W-1:0] fg_diff_sum;
  logic [ppd_pkg::CNT_OUT_W-1:0] fg_close_total;
  logic [ppd_pkg::CNT_OUT_W-1:0] union_total;
  logic [ppd_pkg::CNT_OUT_W-1:0] overlap_total;
  logic                          saturated;

  pixel_pair_diff_metrics #(
    .COUNT_BITS(ACC_BITS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .left_pixel    (left_pixel),
    .right_pixel   (right_pixel),
    .mask_pixel    (mask_pixel),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_total  (sample_total),
    .diff_sum      (diff_sum),
    .close_total   (close_total),
    .fg_total      (fg_total),
    .fg_diff_sum   (fg_diff_sum),
    .fg_close_total(fg_close_total),
    .union_total   (union_total),
    .overlap_total (overlap_total),
    .saturated     (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: register copy, running frame totals, sticky flag
  // ---------------------------------------------------------------------
  ppd_pkg::cfg_t cfg_shadow = '{alpha_limit: ppd_pkg::ALPHA_LIMIT_RST,
                                dark_limit: ppd_pkg::DARK_LIMIT_RST,
                                visibility_by_alpha: 1'b0,
                                mask_enable: 1'b0};

  longint unsigned acc_sample = 0, acc_diff = 0, acc_close = 0, acc_fg = 0;
  longint unsigned acc_fg_diff = 0, acc_fg_close = 0, acc_union = 0, acc_overlap = 0;
  logic            sat_sticky = 1'b0;

  ppd_pkg::sample_t pending_q[$];   // beats waiting for the driver
  frame_totals_t    totals_q[$];    // frame results still owed by the block

  // run bookkeeping
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit pressure_on = 1'b0;
  int mismatches = 0;
  int beats_in = 0;
  int frames_checked = 0;
  int sat_frames = 0;
  int cfg_writes = 0;
  int backpressure_cycles = 0;
  int frame_left = 0;

  function automatic logic [7:0] max_rgb(input logic [31:0] px);
    logic [7:0] m;
    m = px[7:0];
    if (px[15:8] > m) m = px[15:8];
    if (px[23:16] > m) m = px[23:16];
    return m;
  endfunction

  function automatic logic pixel_visible(input logic [31:0] px);
    if (cfg_shadow.visibility_by_alpha)
      return px[31:24] > cfg_shadow.alpha_limit;
    return max_rgb(px) > cfg_shadow.dark_limit;
  endfunction

  // Clamp-at-limit add; reaching the limit sets the sticky flag.
  function automatic longint unsigned sat_add(input longint unsigned acc,
                                              input longint unsigned amt,
                                              input longint unsigned lim);
    longint unsigned v;
    v = (acc > lim) ? lim : acc;
    v = (amt >= lim - v) ? lim : v + amt;
    if (v == lim) sat_sticky = 1'b1;
    return v;
  endfunction

  // Fold one accepted beat into the running totals; on frame_end, queue
  // the frame result and clear the totals (the sticky flag survives).
  task automatic fold_sample(input ppd_pkg::sample_t s);
    frame_totals_t done;
    int unsigned   a, b, d, delta_sum, worst;
    logic          lv, rv, fg, is_close;
    delta_sum = 0;
    worst = 0;
    for (int k = 0; k < 4; k++) begin
      a = s.left_pixel[8*k +: 8];
      b = s.right_pixel[8*k +: 8];
      d = (a > b) ? a - b : b - a;
      delta_sum += d;
      if (d > worst) worst = d;
    end
    is_close = (worst <= ppd_pkg::CLOSE_DELTA);
    lv = pixel_visible(s.left_pixel);
    rv = pixel_visible(s.right_pixel);
    if (cfg_shadow.mask_enable)
      fg = (s.mask_pixel[31:24] > cfg_shadow.alpha_limit) ||
           (max_rgb(s.mask_pixel) > cfg_shadow.alpha_limit);
    else
      fg = lv || rv;

    acc_sample = sat_add(acc_sample, 1, COUNT_LIMIT);
    acc_diff = sat_add(acc_diff, delta_sum, SUM_LIMIT);
    if (is_close) acc_close = sat_add(acc_close, 1, COUNT_LIMIT);
    if (lv || rv) acc_union = sat_add(acc_union, 1, COUNT_LIMIT);
    if (lv && rv) acc_overlap = sat_add(acc_overlap, 1, COUNT_LIMIT);
    if (fg) begin
      acc_fg = sat_add(acc_fg, 1, COUNT_LIMIT);
      acc_fg_diff = sat_add(acc_fg_diff, delta_sum, SUM_LIMIT);
      if (is_close) acc_fg_close = sat_add(acc_fg_close, 1, COUNT_LIMIT);
    end

    if (s.frame_end) begin
      done.sample_cnt   = acc_sample[ppd_pkg::CNT_OUT_W-1:0];
      done.diff_acc     = acc_diff[ppd_pkg::SUM_OUT_W-1:0];
      done.close_cnt    = acc_close[ppd_pkg::CNT_OUT_W-1:0];
      done.fg_cnt       = acc_fg[ppd_pkg::CNT_OUT_W-1:0];
      done.fg_diff_acc  = acc_fg_diff[ppd_pkg::SUM_OUT_W-1:0];
      done.fg_close_cnt = acc_fg_close[ppd_pkg::CNT_OUT_W-1:0];
      done.union_cnt    = acc_union[ppd_pkg::CNT_OUT_W-1:0];
      done.overlap_cnt  = acc_overlap[ppd_pkg::CNT_OUT_W-1:0];
      done.sat          = sat_sticky;
      totals_q.push_back(done);
      acc_sample = 0; acc_diff = 0; acc_close = 0; acc_fg = 0;
      acc_fg_diff = 0; acc_fg_close = 0; acc_union = 0; acc_overlap = 0;
    end
  endtask

  // Gap length: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one beat at a time from pending_q, random gaps between beats
  // ---------------------------------------------------------------------
  ppd_pkg::sample_t cur_beat;
  int               tx_gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap_left = 0;
    end else begin
      if (in_valid && in_stall) backpressure_cycles++;
      if (in_valid && !in_stall) begin
        fold_sample(cur_beat);
        beats_in++;
      end
      // slot is free when nothing is offered or the offered beat just went
      if (!in_valid || !in_stall) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_beat = pending_q.pop_front();
          in_valid <= 1'b1;
          left_pixel <= cur_beat.left_pixel;
          right_pixel <= cur_beat.right_pixel;
          mask_pixel <= cur_beat.mask_pixel;
          frame_end <= cur_beat.frame_end;
          tx_gap_left = tx_gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver stall: random hold-offs, plus one long hold in the pressure
  // phase so the result register stays full and frame_end beats back up
  // ---------------------------------------------------------------------
  int hold_left = 0;
  int stall_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= (hold_left != 0);
    end else if (pressure_on && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = rx_gaps_on ? pick_gap() : 0;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every result beat against the oldest owed frame
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_totals_t want;
    if (!rst && out_valid && !out_stall) begin
      if (totals_q.size() == 0) begin
        $error("result beat with no frame outstanding");
        mismatches++;
      end else begin
        want = totals_q.pop_front();
        check_field("sample_total", want.sample_cnt, sample_total);
        check_field("diff_sum", want.diff_acc, diff_sum);
        check_field("close_total", want.close_cnt, close_total);
        check_field("fg_total", want.fg_cnt, fg_total);
        check_field("fg_diff_sum", want.fg_diff_acc, fg_diff_sum);
        check_field("fg_close_total", want.fg_close_cnt, fg_close_total);
        check_field("union_total", want.union_cnt, union_total);
        check_field("overlap_total", want.overlap_cnt, overlap_total);
        check_field("saturated", want.sat, saturated);
        frames_checked++;
        if (saturated) sat_frames++;
      end
    end
  end

  // Watchdog: any accepted beat or register write restarts the count.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: nothing accepted for %0d cycles, %0d frames still owed",
                 WATCHDOG_LIMIT, totals_q.size());
        $display("pixel_pair_diff_metrics verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [ppd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ppd_pkg::CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    // only the register's own width is kept
    case (idx)
      ppd_pkg::REG_ALPHA_LIMIT:  cfg_shadow.alpha_limit = data;
      ppd_pkg::REG_DARK_LIMIT:   cfg_shadow.dark_limit = data;
      ppd_pkg::REG_VIS_BY_ALPHA: cfg_shadow.visibility_by_alpha = data[0];
      ppd_pkg::REG_MASK_ENABLE:  cfg_shadow.mask_enable = data[0];
      default: ;
    endcase
  endtask

  // Wait for the driver to empty, every owed frame to arrive, then let the
  // pipe run dry (a trailing non-final beat produces no result to wait on).
  task automatic settle();
    @(negedge clk);
    while (pending_q.size() != 0 || in_valid || totals_q.size() != 0)
      @(negedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  function automatic void queue_sample(input logic [31:0] l, input logic [31:0] r,
                                       input logic [31:0] m, input logic last);
    ppd_pkg::sample_t s;
    s.left_pixel = l;
    s.right_pixel = r;
    s.mask_pixel = m;
    s.frame_end = last;
    pending_q.push_back(s);
  endfunction

  // Byte biased toward a threshold, the rails and small values.
  function automatic logic [7:0] pick_byte(input logic [7:0] thr);
    int t;
    case ($urandom_range(0, 3))
      0: t = $urandom_range(0, 255);
      1: t = int'(thr) + int'($urandom_range(0, 2)) - 1;
      2: t = $urandom_range(0, 1) ? 255 : 0;
      default: t = $urandom_range(0, 16);
    endcase
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic logic [31:0] random_pixel();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return {pick_byte(cfg_shadow.alpha_limit), pick_byte(cfg_shadow.dark_limit),
            pick_byte(cfg_shadow.dark_limit), pick_byte(cfg_shadow.dark_limit)};
  endfunction

  // Per-channel jitter of +-10 around a pixel, to straddle the close limit.
  function automatic logic [31:0] nudge(input logic [31:0] px);
    logic [31:0] q;
    int          t;
    for (int k = 0; k < 4; k++) begin
      t = int'(px[8*k +: 8]) + int'($urandom_range(0, 20)) - 10;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      q[8*k +: 8] = t[7:0];
    end
    return q;
  endfunction

  // Frames of random length; a frame may run across a phase boundary.
  function automatic void push_frames(input int n, input int max_len);
    logic [31:0] l, r, m;
    for (int i = 0; i < n; i++) begin
      if (frame_left == 0)
        frame_left = ($urandom_range(0, 99) < 85) ?
                     $urandom_range(1, (max_len < 10) ? max_len : 10) :
                     $urandom_range(1, max_len);
      l = random_pixel();
      r = $urandom_range(0, 1) ? nudge(l) : random_pixel();
      m = ($urandom_range(0, 4) == 0) ? $urandom :
          {pick_byte(cfg_shadow.alpha_limit), pick_byte(cfg_shadow.alpha_limit),
           pick_byte(cfg_shadow.alpha_limit), pick_byte(cfg_shadow.alpha_limit)};
      queue_sample(l, r, m, frame_left == 1);
      frame_left--;
    end
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: alpha 8, dark 4, brightness mode, no mask.
    @(negedge clk);
    queue_sample(32'h0000_0000, 32'h0000_0000, 32'h0, 1'b1);  // all-zero one-beat frame
    queue_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 1'b1);  // largest possible delta
    queue_sample(32'h0000_0000, 32'h0808_0808, 32'h0, 1'b0);  // delta of exactly 8: close
    queue_sample(32'h0000_0000, 32'h0900_0000, 32'h0, 1'b0);  // 9 on alpha: not close
    queue_sample(32'h0000_0004, 32'h0000_0500, 32'h0, 1'b0);  // B at limit dark, G above
    queue_sample(32'h0005_0000, 32'h0000_0005, 32'h0, 1'b1);  // both visible
    settle();

    // Alpha mode at the lowest alpha limit, darkest limit at the top.
    // Upper data bits on the 1-bit register must be dropped.
    write_reg(ppd_pkg::REG_VIS_BY_ALPHA, 8'hFF);
    write_reg(ppd_pkg::REG_ALPHA_LIMIT, 8'd0);
    write_reg(ppd_pkg::REG_DARK_LIMIT, 8'd255);
    @(negedge clk);
    queue_sample(32'h00FF_FFFF, 32'h0100_0000, 32'h0, 1'b0);  // alpha 0 hidden, 1 shown
    queue_sample(32'hFF00_0000, 32'hFFFF_FFFF, 32'h0, 1'b1);
    settle();

    // Mask on with alpha limit at the top: no mask pixel can be foreground.
    write_reg(ppd_pkg::REG_MASK_ENABLE, 8'hFF);
    write_reg(ppd_pkg::REG_VIS_BY_ALPHA, 8'h02);               // low bit 0: brightness
    write_reg(ppd_pkg::REG_ALPHA_LIMIT, 8'd255);
    write_reg(ppd_pkg::REG_DARK_LIMIT, 8'd0);
    @(negedge clk);
    queue_sample(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    settle();

    // Mask test on each byte around the limit; spare indexes are ignored.
    write_reg(ppd_pkg::REG_ALPHA_LIMIT, 8'd100);
    write_reg(REG_SPARE_FIRST, 8'hFF);
    write_reg(REG_SPARE_LAST, 8'h00);
    @(negedge clk);
    queue_sample(32'h1020_3040, 32'h1121_3141, 32'h6500_0000, 1'b0);  // mask alpha 101
    queue_sample(32'h8080_8080, 32'h0000_0000, 32'h0000_6400, 1'b0);  // G at 100: background
    queue_sample(32'h0000_0000, 32'hFF00_00FF, 32'h0065_0000, 1'b1);  // R at 101
    queue_sample(32'h0403_0201, 32'h0102_0304, 32'h0000_0065, 1'b1);  // B at 101
    settle();

    // Random phases: fresh settings each time, one phase under pressure.
    for (int p = 0; p < 8; p++) begin
      write_reg(ppd_pkg::REG_ALPHA_LIMIT, pick_limit());
      write_reg(ppd_pkg::REG_DARK_LIMIT, pick_limit());
      write_reg(ppd_pkg::REG_VIS_BY_ALPHA, $urandom_range(0, 255));
      write_reg(ppd_pkg::REG_MASK_ENABLE, $urandom_range(0, 255));
      if ($urandom_range(0, 1))
        write_reg($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST), $urandom_range(0, 255));
      @(negedge clk);
      if (p == 3) begin
        // short frames at full rate into a receiver that stops taking
        tx_gaps_on = 1'b0;
        pressure_on = 1'b1;
        push_frames(70, 3);
      end else begin
        tx_gaps_on = ($urandom_range(0, 9) < 7);
        rx_gaps_on = ($urandom_range(0, 9) < 7);
        push_frames(70, 40);
      end
      settle();
      pressure_on = 1'b0;
    end

    // One long frame of largest deltas followed by random samples, then
    // a few short frames.
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    write_reg(ppd_pkg::REG_VIS_BY_ALPHA, 8'h00);
    write_reg(ppd_pkg::REG_DARK_LIMIT, 8'd0);
    write_reg(ppd_pkg::REG_MASK_ENABLE, 8'h00);
    @(negedge clk);
    for (int i = 0; i < SAT_FRAME_LEN; i++) begin
      if (i < SAT_FRAME_LEN - 30)
        queue_sample((i % 2) ? 32'hFFFF_FFFF : 32'h0,
                     (i % 2) ? 32'h0 : 32'hFFFF_FFFF, $urandom, 1'b0);
      else
        queue_sample(random_pixel(), random_pixel(), $urandom, i == SAT_FRAME_LEN - 1);
    end
    frame_left = 0;
    push_frames(20, 5);
    settle();

    $display("covered %0d sample beats, %0d frame results, %0d register writes",
             beats_in, frames_checked, cfg_writes);
    $display("input held off %0d cycles; %0d results carried the saturation flag",
             backpressure_cycles, sat_frames);
    if (mismatches == 0)
      $display("pixel_pair_diff_metrics verification clean");
    else
      $display("pixel_pair_diff_metrics verification failed");
    $finish;
  end

endmodule
